// ===== sv/rrr_pkg.sv =====
// rrr_pkg: shared types, widths and constants for the ray reflect/refract block.
// Depends on nothing; every other file imports it.
`default_nettype none

package rrr_pkg;

   localparam int FRAC_BITS = 14;         // vector fraction bits (Q2.14)
   localparam int IOR_FRAC  = 12;         // index ratio fraction bits (Q4.12)
   localparam int NORM_BITS = 30;         // bit length of largest scaled component
   localparam int VEC_W     = 50;         // unnormalized vector component, signed
   localparam int DOT_W     = 34;         // D.N
   localparam int T_W       = 34;         // ior*cos - sqrt(k)
   localparam int MAG_W     = NORM_BITS + 1;
   localparam int SQ_W      = 62;         // isqrt operand
   localparam int ROOT_W    = 31;
   localparam int DIV_W     = 48;
   localparam int Q_W       = 17;
   localparam int EPS_W     = 17;
   localparam int BL_W      = 6;
   localparam int CNT_W     = 5;
   localparam int LANES     = 3;
   localparam int LANE_W    = 2;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W    = 1;
   localparam int QCNT_W    = 2;

   localparam logic [LANE_W-1:0] LAST_LANE = LANE_W'(LANES - 1);
   localparam logic [EPS_W-1:0]  EPS_RESET = 17'd6554;
   localparam logic [Q_W-1:0]    Q_POS_MAX = 17'd32767;
   localparam logic signed [VEC_W-1:0] POS_MAX = VEC_W'(32'sh7FFF_FFFF);
   localparam logic signed [VEC_W-1:0] POS_MIN = VEC_W'(32'sh8000_0000);

   typedef enum logic {
      KIND_REFLECT = 1'b0,
      KIND_REFRACT = 1'b1
   } ray_kind_type;

   typedef struct packed {
      logic signed [15:0] dir_x;
      logic signed [15:0] dir_y;
      logic signed [15:0] dir_z;
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
      logic signed [15:0] normal_z;
      logic signed [31:0] hit_x;
      logic signed [31:0] hit_y;
      logic signed [31:0] hit_z;
      logic signed [15:0] cos_incidence;
      logic        [15:0] index_ratio;
      logic signed [15:0] refract_discriminant;
   } req_type;

   typedef struct packed {
      req_type hit;
      logic    tir;
   } item_type;

   typedef struct packed {
      logic               ray_kind;
      logic signed [15:0] out_dir_x;
      logic signed [15:0] out_dir_y;
      logic signed [15:0] out_dir_z;
      logic signed [31:0] out_origin_x;
      logic signed [31:0] out_origin_y;
      logic signed [31:0] out_origin_z;
      logic               origin_valid;
      logic               total_internal;
      logic               last;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DOT,
      ST_RVEC,
      ST_NOR,
      ST_NMSB,
      ST_NSCALE,
      ST_NSQ,
      ST_NSQRT_GO,
      ST_NSQRT,
      ST_NDIV_INIT,
      ST_NDIV,
      ST_NOUT,
      ST_ORIG,
      ST_EMIT_REFL,
      ST_KSQRT_GO,
      ST_KSQRT,
      ST_TCALC,
      ST_FVEC,
      ST_EMIT_REFR
   } back_state_type;

   // Divide by 2^FRAC_BITS, rounding half away from zero.
   function automatic logic signed [VEC_W-1:0] round_frac(input logic signed [VEC_W-1:0] x);
      logic [VEC_W-1:0] mag;
      mag = x[VEC_W-1] ? unsigned'(-x) : unsigned'(x);
      mag = (mag + (VEC_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
      return x[VEC_W-1] ? -$signed(mag) : $signed(mag);
   endfunction

endpackage

`default_nettype wire

// ===== sv/rrr_isqrt.sv =====
// rrr_isqrt: iterative integer square root, two operand bits per cycle.
// Depends on rrr_pkg for widths.
`default_nettype none

module rrr_isqrt import rrr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              sq_start,
   input  logic [SQ_W-1:0]   sq_operand,
   output logic              sq_done,
   output logic [ROOT_W-1:0] sq_root
);

   logic            busy_ff;
   logic            done_ff;
   logic [SQ_W-1:0] x_ff;
   logic [SQ_W-1:0] res_ff;
   logic [SQ_W-1:0] bit_ff;
   logic [SQ_W-1:0] trial;
   logic            fits;
   logic            last_step;

   assign trial     = res_ff + bit_ff;
   assign fits      = x_ff >= trial;
   assign last_step = busy_ff && (bit_ff == SQ_W'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= last_step;
         if (sq_start) begin
            busy_ff <= 1'b1;
         end else if (last_step) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (sq_start) begin
         x_ff   <= sq_operand;
         res_ff <= '0;
         bit_ff <= SQ_W'(1) << (SQ_W - 2);
      end else if (busy_ff) begin
         if (fits) begin
            x_ff   <= x_ff - trial;
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

   assign sq_done = done_ff;
   assign sq_root = res_ff[ROOT_W-1:0];

endmodule

`default_nettype wire

// ===== sv/rrr_front.sv =====
// rrr_front: accepts hits, flags total internal reflection, queues them for the back end.
// Depends on rrr_pkg for item types.
`default_nettype none

module rrr_front import rrr_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  req_type  req_hit,
   output logic     busy,
   output logic     q_valid,
   output item_type q_item,
   input  logic     q_pop
);

   item_type            mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff;
   logic                push;
   item_type            entry;

   assign busy    = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign push    = start && !busy;
   assign q_valid = count_ff != '0;
   assign q_item  = mem_ff[rd_ptr_ff];

   // classify: negative discriminant means no refracted ray
   always_comb begin
      entry.hit = req_hit;
      entry.tir = req_hit.refract_discriminant[15];
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (q_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !q_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (q_pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

// ===== sv/rrr_back.sv =====
// rrr_back: sequencer and datapath that build, normalize and emit both rays of a hit.
// Depends on rrr_pkg; drives an external rrr_isqrt unit.
`default_nettype none

module rrr_back import rrr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic [EPS_W-1:0]  offset_epsilon,
   input  logic              q_valid,
   input  item_type          q_item,
   output logic              q_pop,
   output logic              sq_start,
   output logic [SQ_W-1:0]   sq_operand,
   input  logic              sq_done,
   input  logic [ROOT_W-1:0] sq_root,
   output logic              rsp_valid,
   output rsp_type           rsp_ray
);

   back_state_type state_ff, state_in;

   logic signed [15:0]      d_ff [LANES];
   logic signed [15:0]      n_ff [LANES];
   logic signed [31:0]      p_ff [LANES];
   logic signed [15:0]      cos_ff;
   logic [15:0]             ior_ff;
   logic [15:0]             k_ff;
   logic                    tir_ff;
   logic                    kind_ff;
   logic signed [DOT_W-1:0] dot_ff;
   logic signed [VEC_W-1:0] v_ff [LANES];
   logic [VEC_W-1:0]        or_ff;
   logic [BL_W-1:0]         msb_ff;
   logic [MAG_W-1:0]        cmag_ff [LANES];
   logic                    cneg_ff [LANES];
   logic [SQ_W-1:0]         len2_ff;
   logic [ROOT_W-1:0]       len_ff;
   logic [DIV_W-1:0]        rem_ff [LANES];
   logic [DIV_W-1:0]        dvs_ff;
   logic [Q_W-1:0]          quo_ff [LANES];
   logic signed [15:0]      r_ff [LANES];
   logic signed [31:0]      o_ff [LANES];
   logic [14:0]             s_ff;
   logic signed [T_W-1:0]   t_ff;
   logic [LANE_W-1:0]       idx_ff;
   logic [CNT_W-1:0]        cnt_ff;
   logic                    rsp_valid_ff;
   rsp_type                 rsp_ff;

   logic                    emit;
   logic                    lane_last;
   back_state_type          post_norm;

   // datapath terms
   logic signed [31:0]      dn [LANES];
   logic signed [VEC_W-1:0] dotn;
   logic signed [VEC_W-1:0] rvec;
   logic signed [32:0]      irc;
   logic signed [T_W-1:0]   s_ext;
   logic signed [T_W-1:0]   tval;
   logic signed [32:0]      id;
   logic signed [VEC_W-1:0] nt;
   logic signed [VEC_W-1:0] fvec;
   logic [VEC_W-1:0]        vmag [LANES];
   logic [VEC_W-1:0]        or_mag;
   logic [BL_W-1:0]         probe;
   logic                    probe_hit;
   logic [BL_W-1:0]         blen;
   logic [BL_W-1:0]         rsh;
   logic [BL_W-1:0]         lsh;
   logic [VEC_W-1:0]        cwide;
   logic [SQ_W-1:0]         csq;
   logic                    ge [LANES];
   logic signed [15:0]      rsat [LANES];
   logic [Q_W-1:0]          negq [LANES];
   logic signed [33:0]      reps;
   logic signed [VEC_W-1:0] osum;
   logic signed [31:0]      oclamp;

   assign lane_last = idx_ff == LAST_LANE;
   assign post_norm = kind_ff ? ST_EMIT_REFR : ST_ORIG;

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         dn[i]   = d_ff[i] * n_ff[i];
         vmag[i] = v_ff[i][VEC_W-1] ? unsigned'(-v_ff[i]) : unsigned'(v_ff[i]);
      end
      or_mag = vmag[0] | vmag[1] | vmag[2];

      // reflected: D*2^F - 2*round(D.N*N / 2^F)
      dotn = dot_ff * n_ff[idx_ff];
      rvec = (VEC_W'(d_ff[idx_ff]) <<< FRAC_BITS) - (round_frac(dotn) <<< 1);

      // refracted: ior*D*2^F + N*(ior*cos - sqrt(k)*2^12)
      irc   = $signed({1'b0, ior_ff}) * cos_ff;
      s_ext = T_W'($signed({1'b0, s_ff}));
      tval  = T_W'(irc) - (s_ext <<< IOR_FRAC);
      id    = $signed({1'b0, ior_ff}) * d_ff[idx_ff];
      nt    = n_ff[idx_ff] * t_ff;
      fvec  = (VEC_W'(id) <<< FRAC_BITS) + nt;

      // leading one search, one bit of the position per cycle
      probe     = msb_ff | (BL_W'(1) << cnt_ff);
      probe_hit = (or_ff >> probe) != '0;

      // scale so the largest component has NORM_BITS bits
      blen = BL_W'(msb_ff + 1'b1);
      rsh  = BL_W'(blen - BL_W'(NORM_BITS));
      lsh  = BL_W'(BL_W'(NORM_BITS) - blen);
      if (blen > BL_W'(NORM_BITS)) begin
         cwide = (vmag[idx_ff] + (VEC_W'(1) << (rsh - 1'b1))) >> rsh;
      end else begin
         cwide = vmag[idx_ff] << lsh;
      end
      csq = SQ_W'(cmag_ff[idx_ff]) * SQ_W'(cmag_ff[idx_ff]);

      for (int i = 0; i < LANES; i++) begin
         ge[i]   = rem_ff[i] >= dvs_ff;
         negq[i] = Q_W'(0) - quo_ff[i];
         if (!cneg_ff[i]) begin
            rsat[i] = (quo_ff[i] > Q_POS_MAX) ? 16'sh7FFF : $signed(quo_ff[i][15:0]);
         end else begin
            rsat[i] = (quo_ff[i] > Q_POS_MAX) ? 16'sh8000 : $signed(negq[i][15:0]);
         end
      end

      // origin offset along the reflected direction
      reps = r_ff[idx_ff] * $signed({1'b0, offset_epsilon});
      osum = VEC_W'(p_ff[idx_ff]) + round_frac(VEC_W'(reps));
      if (osum > POS_MAX) begin
         oclamp = 32'sh7FFF_FFFF;
      end else if (osum < POS_MIN) begin
         oclamp = 32'sh8000_0000;
      end else begin
         oclamp = osum[31:0];
      end
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      q_pop      = 1'b0;
      sq_start   = 1'b0;
      sq_operand = len2_ff;
      emit       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               state_in = ST_DOT;
            end
         end
         ST_DOT:       state_in = ST_RVEC;
         ST_RVEC:      if (lane_last) state_in = ST_NOR;
         ST_NOR:       state_in = (or_mag == '0) ? post_norm : ST_NMSB;
         ST_NMSB:      if (cnt_ff == '0) state_in = ST_NSCALE;
         ST_NSCALE:    if (lane_last) state_in = ST_NSQ;
         ST_NSQ:       if (lane_last) state_in = ST_NSQRT_GO;
         ST_NSQRT_GO: begin
            sq_start = 1'b1;
            state_in = ST_NSQRT;
         end
         ST_NSQRT:     if (sq_done) state_in = ST_NDIV_INIT;
         ST_NDIV_INIT: state_in = ST_NDIV;
         ST_NDIV:      if (cnt_ff == '0) state_in = ST_NOUT;
         ST_NOUT:      state_in = post_norm;
         ST_ORIG:      if (lane_last) state_in = ST_EMIT_REFL;
         ST_EMIT_REFL: begin
            emit     = 1'b1;
            state_in = tir_ff ? ST_EMIT_REFR : ST_KSQRT_GO;
         end
         ST_KSQRT_GO: begin
            sq_start   = 1'b1;
            sq_operand = SQ_W'(k_ff[14:0]) << FRAC_BITS;
            state_in   = ST_KSQRT;
         end
         ST_KSQRT:     if (sq_done) state_in = ST_TCALC;
         ST_TCALC:     state_in = ST_FVEC;
         ST_FVEC:      if (lane_last) state_in = ST_NOR;
         ST_EMIT_REFR: begin
            emit     = 1'b1;
            state_in = ST_IDLE;
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= emit;
      end
   end

   // lane index restarts on every state change
   always_ff @(posedge clock) begin
      idx_ff <= (state_in != state_ff) ? '0 : idx_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            d_ff[0] <= q_item.hit.dir_x;
            d_ff[1] <= q_item.hit.dir_y;
            d_ff[2] <= q_item.hit.dir_z;
            n_ff[0] <= q_item.hit.normal_x;
            n_ff[1] <= q_item.hit.normal_y;
            n_ff[2] <= q_item.hit.normal_z;
            p_ff[0] <= q_item.hit.hit_x;
            p_ff[1] <= q_item.hit.hit_y;
            p_ff[2] <= q_item.hit.hit_z;
            cos_ff  <= q_item.hit.cos_incidence;
            ior_ff  <= q_item.hit.index_ratio;
            k_ff    <= q_item.hit.refract_discriminant;
            tir_ff  <= q_item.tir;
            kind_ff <= KIND_REFLECT;
         end
         ST_DOT:  dot_ff <= DOT_W'(dn[0]) + DOT_W'(dn[1]) + DOT_W'(dn[2]);
         ST_RVEC: v_ff[idx_ff] <= rvec;
         ST_NOR: begin
            or_ff  <= or_mag;
            msb_ff <= '0;
            cnt_ff <= CNT_W'(BL_W - 1);
            if (or_mag == '0) begin
               for (int i = 0; i < LANES; i++) r_ff[i] <= '0;
            end
         end
         ST_NMSB: begin
            if (probe_hit) msb_ff <= probe;
            cnt_ff <= cnt_ff - 1'b1;
         end
         ST_NSCALE: begin
            cmag_ff[idx_ff] <= cwide[MAG_W-1:0];
            cneg_ff[idx_ff] <= v_ff[idx_ff][VEC_W-1];
            len2_ff         <= '0;
         end
         ST_NSQ:   len2_ff <= len2_ff + csq;
         ST_NSQRT: if (sq_done) len_ff <= sq_root;
         ST_NDIV_INIT: begin
            for (int i = 0; i < LANES; i++) begin
               rem_ff[i] <= (DIV_W'(cmag_ff[i]) << FRAC_BITS) + DIV_W'(len_ff >> 1);
               quo_ff[i] <= '0;
            end
            dvs_ff <= DIV_W'(len_ff) << (Q_W - 1);
            cnt_ff <= CNT_W'(Q_W - 1);
         end
         ST_NDIV: begin
            for (int i = 0; i < LANES; i++) begin
               if (ge[i]) rem_ff[i] <= rem_ff[i] - dvs_ff;
               quo_ff[i] <= {quo_ff[i][Q_W-2:0], ge[i]};
            end
            dvs_ff <= dvs_ff >> 1;
            cnt_ff <= cnt_ff - 1'b1;
         end
         ST_NOUT: begin
            for (int i = 0; i < LANES; i++) r_ff[i] <= rsat[i];
         end
         ST_ORIG: o_ff[idx_ff] <= oclamp;
         ST_EMIT_REFL: begin
            kind_ff <= KIND_REFRACT;
            if (tir_ff) begin
               for (int i = 0; i < LANES; i++) r_ff[i] <= '0;
            end
         end
         ST_KSQRT: if (sq_done) s_ff <= sq_root[14:0];
         ST_TCALC: t_ff <= tval;
         ST_FVEC:  v_ff[idx_ff] <= fvec;
         default: ;
      endcase
   end

   // result register
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_ff.ray_kind       <= kind_ff;
         rsp_ff.out_dir_x      <= r_ff[0];
         rsp_ff.out_dir_y      <= r_ff[1];
         rsp_ff.out_dir_z      <= r_ff[2];
         rsp_ff.out_origin_x   <= kind_ff ? '0 : o_ff[0];
         rsp_ff.out_origin_y   <= kind_ff ? '0 : o_ff[1];
         rsp_ff.out_origin_z   <= kind_ff ? '0 : o_ff[2];
         rsp_ff.origin_valid   <= !kind_ff;
         rsp_ff.total_internal <= kind_ff && tir_ff;
         rsp_ff.last           <= kind_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_ray   = rsp_ff;

endmodule

`default_nettype wire

// ===== sv/ray_reflect_refract.sv =====
// ray_reflect_refract: top level. Takes a hit, emits the reflected then refracted ray.
// Depends on rrr_pkg, rrr_front, rrr_back and rrr_isqrt.
// Each hit uses the shared 31-step square root up to three times and up to two 17-step
// lane-parallel divisions; the front queue holds up to two further hits meanwhile.
// The reflected ray leaves before the refracted one, which under total internal
// reflection follows it directly. Reset empties the queue and sets epsilon to 0.1.
`default_nettype none

module ray_reflect_refract import rrr_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   // hit input: transfer when start is high and busy is low
   input  logic             start,
   output logic             busy,
   input  req_type          req_hit,
   // result output: one strobed transfer per ray, cannot be held off
   output logic             rsp_valid,
   output rsp_type          rsp_ray,
   // offset epsilon register, unsigned Q1.16
   input  logic             csr_wr_en,
   input  logic [EPS_W-1:0] csr_wr_data
);

   logic [EPS_W-1:0]  eps_ff;
   logic              q_valid;
   item_type          q_item;
   logic              q_pop;
   logic              sq_start;
   logic [SQ_W-1:0]   sq_operand;
   logic              sq_done;
   logic [ROOT_W-1:0] sq_root;

   // hold epsilon between writes; to be written only while idle, the block does not enforce this
   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= EPS_RESET;
      end else if (csr_wr_en) begin
         eps_ff <= csr_wr_data;
      end
   end

   // front: take hits, flag total internal reflection, queue
   rrr_front u_front (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req_hit (req_hit),
      .busy    (busy),
      .q_valid (q_valid),
      .q_item  (q_item),
      .q_pop   (q_pop)
   );

   // back: build both vectors, normalize, offset origin, emit two transfers
   rrr_back u_back (
      .clock          (clock),
      .reset          (reset),
      .offset_epsilon (eps_ff),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .q_pop          (q_pop),
      .sq_start       (sq_start),
      .sq_operand     (sq_operand),
      .sq_done        (sq_done),
      .sq_root        (sq_root),
      .rsp_valid      (rsp_valid),
      .rsp_ray        (rsp_ray)
   );

   // square root shared by sqrt(k) and the vector length
   rrr_isqrt u_isqrt (
      .clock      (clock),
      .reset      (reset),
      .sq_start   (sq_start),
      .sq_operand (sq_operand),
      .sq_done    (sq_done),
      .sq_root    (sq_root)
   );

endmodule

`default_nettype wire

// ===== sv/rrr_checker.sv =====
// rrr_checker: port-level assertions for ray_reflect_refract, bound to the top level.
// Depends on rrr_pkg for the result type.
`default_nettype none

module rrr_checker import rrr_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input rsp_type rsp_ray
);

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result strobe right after reset");

   a_reflect_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ray.last |->
         rsp_ray.origin_valid && !rsp_ray.total_internal && !rsp_ray.ray_kind)
      else $error("reflected transfer has bad flags");

   a_refract_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ray.last |->
         !rsp_ray.origin_valid && rsp_ray.ray_kind && rsp_ray.out_origin_x == 0
         && rsp_ray.out_origin_y == 0 && rsp_ray.out_origin_z == 0)
      else $error("refracted transfer has bad flags or origin");

   a_tir_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ray.total_internal |->
         rsp_ray.out_dir_x == 0 && rsp_ray.out_dir_y == 0 && rsp_ray.out_dir_z == 0)
      else $error("total internal reflection with nonzero direction");

   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ray.last |=> !rsp_valid)
      else $error("transfer directly after a final ray");

endmodule

bind ray_reflect_refract rrr_checker u_checker (.*);

`default_nettype wire

// ===== dv/tb_ray_reflect_refract.sv =====
// Self-checking testbench for ray_reflect_refract: reflected and refracted rays per hit.
// Depends on rrr_pkg for payload types and on the ray_reflect_refract RTL.
`timescale 1ns / 100ps

module tb_ray_reflect_refract;
   import rrr_pkg::*;

   localparam int STALL_LIMIT = 4000;   // cycles with no transfer before the run is aborted

   // Scoreboard: predicts both rays of each accepted hit and checks arriving rays in order.
   class ray_scoreboard;
      rsp_type          rays_due[$];
      logic [EPS_W-1:0] eps;
      int               mismatches;
      int               rays_seen;
      int               hits_seen;
      int               tir_seen;

      function new();
         eps = EPS_RESET;
         mismatches = 0;
         rays_seen = 0;
         hits_seen = 0;
         tir_seen = 0;
      endfunction

      // divide by 2^s, rounding half away from zero
      function longint shift_round(longint x, int s);
         longint unsigned a;
         if (s == 0) return x;
         a = (x < 0) ? longint'(-x) : x;
         a = (a + (64'd1 << (s - 1))) >> s;
         return (x < 0) ? -longint'(a) : longint'(a);
      endfunction

      function longint unsigned root_floor(longint unsigned x);
         longint unsigned res, b;
         res = 0;
         b = 64'h4000_0000_0000_0000;
         while (b > x) b >>= 2;
         while (b != 0) begin
            if (x >= res + b) begin
               x -= res + b;
               res = (res >> 1) + b;
            end else begin
               res >>= 1;
            end
            b >>= 2;
         end
         return res;
      endfunction

      function void unit_dir(input longint v[3], output longint r[3]);
         longint unsigned m, len2, len, num, q;
         longint c[3];
         int bl;
         m = 0;
         len2 = 0;
         bl = 0;
         for (int i = 0; i < 3; i++) begin
            num = (v[i] < 0) ? longint'(-v[i]) : v[i];
            if (num > m) m = num;
         end
         if (m == 0) begin
            r[0] = 0; r[1] = 0; r[2] = 0;
            return;
         end
         while (bl < 64 && (m >> bl) != 0) bl++;
         for (int i = 0; i < 3; i++) begin
            if (bl > NORM_BITS) c[i] = shift_round(v[i], bl - NORM_BITS);
            else c[i] = v[i] * (longint'(1) << (NORM_BITS - bl));
         end
         for (int i = 0; i < 3; i++) begin
            num = (c[i] < 0) ? longint'(-c[i]) : c[i];
            len2 += num * num;
         end
         len = root_floor(len2);
         for (int i = 0; i < 3; i++) begin
            num = ((c[i] < 0) ? longint'(-c[i]) : c[i]) << FRAC_BITS;
            q = (len == 0) ? 0 : (num + len / 2) / len;
            if (q > 32767 && c[i] >= 0) q = 32767;
            if (q > 32768) q = 32768;
            r[i] = (c[i] < 0) ? -longint'(q) : longint'(q);
         end
      endfunction

      // Note one accepted hit: queue its reflected ray, then its refracted ray.
      function void note_hit(req_type h);
         longint d[3], n[3], p[3], v[3], r[3];
         longint dotp, ior, cosi, k, t, o, s;
         rsp_type refl, refr;
         d[0] = h.dir_x; d[1] = h.dir_y; d[2] = h.dir_z;
         n[0] = h.normal_x; n[1] = h.normal_y; n[2] = h.normal_z;
         p[0] = h.hit_x; p[1] = h.hit_y; p[2] = h.hit_z;
         cosi = h.cos_incidence;
         ior = longint'(h.index_ratio);
         k = h.refract_discriminant;
         hits_seen++;
         dotp = d[0] * n[0] + d[1] * n[1] + d[2] * n[2];
         for (int i = 0; i < 3; i++)
            v[i] = d[i] * (longint'(1) << FRAC_BITS)
                 - 2 * shift_round(dotp * n[i], FRAC_BITS);
         unit_dir(v, r);
         refl = '0;
         refl.ray_kind = KIND_REFLECT;
         refl.out_dir_x = r[0][15:0];
         refl.out_dir_y = r[1][15:0];
         refl.out_dir_z = r[2][15:0];
         for (int i = 0; i < 3; i++) begin
            o = p[i] + shift_round(r[i] * longint'(eps), FRAC_BITS);
            if (o > 64'sd2147483647) o = 64'sd2147483647;
            if (o < -64'sd2147483648) o = -64'sd2147483648;
            if (i == 0) refl.out_origin_x = o[31:0];
            if (i == 1) refl.out_origin_y = o[31:0];
            if (i == 2) refl.out_origin_z = o[31:0];
         end
         refl.origin_valid = 1'b1;
         rays_due.push_back(refl);

         refr = '0;
         refr.ray_kind = KIND_REFRACT;
         refr.last = 1'b1;
         if (k < 0) begin
            refr.total_internal = 1'b1;
            tir_seen++;
         end else begin
            s = longint'(root_floor(longint'(k) << FRAC_BITS));
            t = ior * cosi - s * (longint'(1) << IOR_FRAC);
            for (int i = 0; i < 3; i++)
               v[i] = ior * d[i] * (longint'(1) << FRAC_BITS) + n[i] * t;
            unit_dir(v, r);
            refr.out_dir_x = r[0][15:0];
            refr.out_dir_y = r[1][15:0];
            refr.out_dir_z = r[2][15:0];
         end
         rays_due.push_back(refr);
      endfunction

      // Check one ray against the oldest prediction.
      function void check_ray(rsp_type got);
         rsp_type e;
         bit bad;
         rays_seen++;
         if (rays_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("ERROR: unexpected ray %h", got);
            return;
         end
         e = rays_due.pop_front();
         bad = (got.ray_kind != e.ray_kind) || (got.out_dir_x != e.out_dir_x) ||
               (got.out_dir_y != e.out_dir_y) || (got.out_dir_z != e.out_dir_z) ||
               (got.out_origin_x != e.out_origin_x) || (got.out_origin_y != e.out_origin_y) ||
               (got.out_origin_z != e.out_origin_z) || (got.origin_valid != e.origin_valid) ||
               (got.total_internal != e.total_internal) || (got.last != e.last);
         if (bad) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("ERROR: ray %0d kind exp %0d got %0d dir exp %0d %0d %0d got %0d %0d %0d",
                        rays_seen, e.ray_kind, got.ray_kind,
                        e.out_dir_x, e.out_dir_y, e.out_dir_z,
                        got.out_dir_x, got.out_dir_y, got.out_dir_z);
               $display("  origin exp %h %h %h got %h %h %h",
                        e.out_origin_x, e.out_origin_y, e.out_origin_z,
                        got.out_origin_x, got.out_origin_y, got.out_origin_z);
               $display("  flags(ov,tir,last) exp %b%b%b got %b%b%b",
                        e.origin_valid, e.total_internal, e.last,
                        got.origin_valid, got.total_internal, got.last);
            end
         end
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   req_type          req_hit;
   logic             rsp_valid;
   rsp_type          rsp_ray;
   logic             csr_wr_en;
   logic [EPS_W-1:0] csr_wr_data;

   ray_scoreboard    sb = new();
   int               stall_cycles;

   ray_reflect_refract DUT (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_hit     (req_hit),
      .rsp_valid   (rsp_valid),
      .rsp_ray     (rsp_ray),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // Sample at the rising edge: outputs here still hold their pre-edge values.
   always @(posedge clock) begin
      if (reset) begin
         stall_cycles <= 0;
      end else begin
         if (csr_wr_en) sb.eps = csr_wr_data;
         if (start && !busy) sb.note_hit(req_hit);
         if (rsp_valid) sb.check_ray(rsp_ray);
         if ((start && !busy) || rsp_valid) stall_cycles <= 0;
         else stall_cycles <= stall_cycles + 1;
      end
   end

   // Abort when nothing has transferred for too long.
   always @(posedge clock) begin
      if (stall_cycles >= STALL_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles, %0d rays outstanding",
                  stall_cycles, sb.rays_due.size());
         $display("tb: failure");
         $finish;
      end
   end

   // Build one hit: tidy gives unit-scale vectors with mostly nonnegative k, else raw noise.
   function automatic req_type random_hit(bit tidy);
      req_type h;
      h = req_type'(240'({$urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom, $urandom, $urandom}));
      if (tidy) begin
         h.dir_x = 16'($signed($urandom_range(32768)) - 16384);
         h.dir_y = 16'($signed($urandom_range(32768)) - 16384);
         h.dir_z = 16'($signed($urandom_range(32768)) - 16384);
         h.normal_x = 16'($signed($urandom_range(32768)) - 16384);
         h.normal_y = 16'($signed($urandom_range(32768)) - 16384);
         h.normal_z = 16'($signed($urandom_range(32768)) - 16384);
         h.hit_x = $signed($urandom_range(32'h00FF_FFFF)) - 32'sh0080_0000;
         h.hit_y = $signed($urandom_range(32'h00FF_FFFF)) - 32'sh0080_0000;
         h.hit_z = $signed($urandom_range(32'h00FF_FFFF)) - 32'sh0080_0000;
         h.cos_incidence = 16'($signed($urandom_range(32768)) - 16384);
         h.index_ratio = 16'($urandom_range(2048, 8192));
         if ($urandom_range(9) < 8) h.refract_discriminant = 16'($urandom_range(16384));
         else h.refract_discriminant = 16'(-$signed($urandom_range(1, 16384)));
      end
      return h;
   endfunction

   // Directed hits: field extremes, zero vectors, grazing and total internal reflection.
   function automatic req_type directed_hit(int i);
      req_type h;
      h = '0;
      h.dir_x = -16'sd16384;
      h.normal_z = 16'sd16384;
      h.dir_z = -16'sd11585;
      h.cos_incidence = 16'sd11585;
      h.index_ratio = 16'd4096;
      h.refract_discriminant = 16'sd8192;
      case (i)
         0: ;
         1: h = '0;                                             // zero direction and normal
         2: h.refract_discriminant = -16'sd1;                   // total internal reflection
         3: h.refract_discriminant = -16'sd32768;
         4: h.refract_discriminant = 16'sd0;                    // grazing, sqrt of zero
         5: h.refract_discriminant = 16'sd32767;
         6: h.index_ratio = 16'd0;
         7: h.index_ratio = 16'hFFFF;
         8: begin
            h.dir_x = 16'sh7FFF; h.dir_y = 16'sh7FFF; h.dir_z = 16'sh7FFF;
            h.normal_x = 16'sh7FFF; h.normal_y = 16'sh7FFF; h.normal_z = 16'sh7FFF;
         end
         9: begin
            h.dir_x = -16'sd32768; h.dir_y = -16'sd32768; h.dir_z = -16'sd32768;
            h.normal_x = -16'sd32768; h.normal_y = 16'sh7FFF; h.normal_z = -16'sd32768;
            h.cos_incidence = -16'sd32768;
         end
         10: begin
            h.hit_x = 32'sh7FFF_FFFF; h.hit_y = 32'sh7FFF_FFFF; h.hit_z = 32'sh7FFF_FFFF;
            h.dir_x = 16'sd16384; h.normal_z = 16'sd0; h.dir_z = 16'sd0;
         end
         11: begin
            h.hit_x = -32'sh8000_0000; h.hit_y = -32'sh8000_0000; h.hit_z = -32'sh8000_0000;
         end
         12: h.cos_incidence = 16'sh7FFF;
         13: begin
            h.normal_z = 16'sd0;                                // refraction along D only
            h.cos_incidence = 16'sd0;
            h.refract_discriminant = 16'sd0;
         end
         14: begin
            h.dir_x = 16'sd0; h.dir_z = 16'sd0;                 // zero D, refracted from N
         end
         15: begin
            h.dir_x = 16'sd1; h.dir_z = 16'sd0; h.normal_z = 16'sd0;
         end
         16: h = '1;
         17: begin
            h.dir_x = 16'sd0; h.dir_z = -16'sd16384;            // head-on hit
            h.cos_incidence = 16'sd16384;
         end
         default: h = random_hit(1'b0);
      endcase
      return h;
   endfunction

   // Present one hit; returns at the falling edge after its transfer.
   task automatic send_hit(req_type h, int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      start = 1'b1;
      req_hit = h;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   // Hold off until every predicted ray has arrived.
   task automatic drain_rays();
      start = 1'b0;
      while (sb.rays_due.size() != 0) @(negedge clock);
   endtask

   // Change epsilon only with the block idle.
   task automatic write_epsilon(logic [EPS_W-1:0] value);
      drain_rays();
      repeat (20) @(negedge clock);
      csr_wr_en = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   initial begin
      logic [EPS_W-1:0] eps_plan[6];
      int               idle_plan[6];
      start = 1'b0;
      req_hit = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      reset = 1'b1;
      eps_plan = '{17'd65536, 17'd0, 17'd1, 17'd6554, 17'd0, 17'd0};
      idle_plan = '{13, 13, 55, 55, 0, 0};
      eps_plan[4] = 17'($urandom_range(65536));
      eps_plan[5] = 17'($urandom_range(65536));
      repeat (12) @(negedge clock);
      reset = 1'b0;

      // directed hits under the reset value of epsilon
      for (int i = 0; i < 20; i++) send_hit(directed_hit(i), 0);

      for (int ph = 0; ph < 6; ph++) begin
         write_epsilon(eps_plan[ph]);
         for (int i = 0; i < 150; i++) begin
            if (ph == 1 && i == 75) drain_rays();   // pause the sender once until empty
            if (i < 3) send_hit(directed_hit(10 + i % 2), idle_plan[ph]);
            else send_hit(random_hit($urandom_range(9) < 7), idle_plan[ph]);
         end
      end
      start = 1'b0;

      drain_rays();
      repeat (200) @(negedge clock);
      $display("run: %0d hits, %0d rays checked, %0d total internal, six epsilon settings",
               sb.hits_seen, sb.rays_seen, sb.tir_seen);
      if (sb.mismatches == 0 && sb.rays_due.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("%0d mismatches, %0d rays never arrived", sb.mismatches, sb.rays_due.size());
         $display("tb: failure");
      end
      $finish;
   end

endmodule
